// ===== design/tarwq_pkg.sv =====
// ----------------------------------------------------------------------------
// tarwq_pkg: task ready and wait queue types
// Beat payloads and operation/status codes shared by the queue engine.
// ----------------------------------------------------------------------------
package tarwq_pkg;

	localparam logic [1:0] FUNC_CREATE   = 2'd0;
	localparam logic [1:0] FUNC_SCHEDULE = 2'd1;
	localparam logic [1:0] FUNC_SLEEP    = 2'd2;
	localparam logic [1:0] FUNC_WAKEUP   = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] channel;
		logic [3:0] current_task;
	} req_t;

	typedef struct packed {
		logic [3:0] task_id;
		logic [1:0] status;
	} rsp_t;

endpackage

// ===== design/task_ready_and_wait_queues.sv =====
// ----------------------------------------------------------------------------
// task_ready_and_wait_queues: kernel queue engine for task IDs
// Ready queue and per-channel wait queues, kept as FIFO linked lists in a
// link memory, with wait-queue heads in a second memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Beat
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall| func, channel, current_task
//  rsp     | out       | rsp_valid/rsp_stall| task_id, status
//
// One request beat is worked on at a time; its response beat is offered
// in S_DONE once the operation ends, and leaves when not stalled. The next
// request is taken in the cycle after the response is loaded. The response
// time is set by the tail walk of an append, which follows one link per
// cycle through the single read port of the link memory.
// Reset clears the heads, the allocation count and the wait-head valid
// bits at once; there is no clearing pass. A stalled response beat is held
// in the output register while the next request is already taken.
module task_ready_and_wait_queues #(
	parameter int NUM_TASKS    = 15,
	parameter int NUM_CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  tarwq_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output tarwq_pkg::rsp_t  rsp
);
	import tarwq_pkg::*;

	// ID and channel index widths
	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS + 1) : 1;
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IW-1:0] NT      = IW'(NUM_TASKS);
	localparam logic [IW-1:0] NT_LAST = IW'(NUM_TASKS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_AP_START,
		S_AP_WALK,
		S_AP_CLR,
		S_POP_START,
		S_POP_RD,
		S_DONE
	} state_t;

	function automatic logic id_ok(input logic [IW-1:0] v);
		return (v != '0) && (v <= NT);
	endfunction

	// channel modulo NUM_CHANNELS on a 3-bit value, by repeated subtraction
	function automatic logic [CW-1:0] ch_mod(input logic [2:0] c_in);
		logic [2:0] c;
		c = c_in;
		for (int i = 0; i < 7; i++) begin
			if (int'(c) >= NUM_CHANNELS) begin
				c = c - 3'(NUM_CHANNELS);
			end
		end
		return CW'(c);
	endfunction

	// control state
	state_t          state_q, state_d;
	logic [1:0]      op_q, op_d;
	logic            tgt_ready_q, tgt_ready_d;
	logic [IW-1:0]   alloc_q, alloc_d;
	logic [IW-1:0]   ready_head_q, ready_head_d;
	logic            whv_q [NUM_CHANNELS];
	logic            rsp_valid_q, rsp_valid_d;
	rsp_t            rsp_q, rsp_d;

	// working registers
	logic [CW-1:0]   ch_q, ch_d;
	logic [IW-1:0]   app_id_q, app_id_d;
	logic [IW-1:0]   walk_q, walk_d;
	logic [IW-1:0]   steps_q, steps_d;
	logic [IW-1:0]   res_id_q, res_id_d;
	logic [1:0]      res_st_q, res_st_d;

	// link memory
	logic [IW-1:0]   nl_mem [NUM_TASKS + 1];
	logic            nl_we, nl_re;
	logic [IW-1:0]   nl_waddr, nl_wdata, nl_raddr;
	logic [IW-1:0]   nl_rd_q;

	// wait-head memory
	logic [IW-1:0]   wh_mem [NUM_CHANNELS];
	logic            wh_we, wh_re;
	logic [IW-1:0]   wh_wdata;
	logic [CW-1:0]   wh_raddr;
	logic [IW-1:0]   wh_rd_q;
	logic            whv_rd_q;

	logic [IW-1:0]   head_cur;
	logic            cur_ok;
	logic            ap_end, pop_end;
	logic [IW-1:0]   pop_top;
	logic            head_we;
	logic [IW-1:0]   head_val;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// head of the queue being worked on
	assign head_cur = tgt_ready_q ? ready_head_q : (whv_rd_q ? wh_rd_q : '0);
	assign cur_ok   = (req.current_task != 4'd0) &&
	                  (9'(req.current_task) <= 9'(NUM_TASKS));

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		tgt_ready_d = tgt_ready_q;
		alloc_d     = alloc_q;
		ch_d        = ch_q;
		app_id_d    = app_id_q;
		walk_d      = walk_q;
		steps_d     = steps_q;
		res_id_d    = res_id_q;
		res_st_d    = res_st_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		nl_we       = 1'b0;
		nl_waddr    = '0;
		nl_wdata    = '0;
		nl_re       = 1'b0;
		nl_raddr    = '0;
		wh_re       = 1'b0;
		wh_raddr    = ch_mod(req.channel);
		head_we     = 1'b0;
		head_val    = '0;
		ap_end      = 1'b0;
		pop_end     = 1'b0;
		pop_top     = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					// fetch the channel's wait head alongside the decode
					op_d  = req.func;
					ch_d  = ch_mod(req.channel);
					wh_re = 1'b1;
					unique case (req.func)
						FUNC_CREATE: begin
							if (alloc_q == NT) begin
								res_id_d = '0;
								res_st_d = STAT_FULL;
								state_d  = S_DONE;
							end else begin
								// slots are never freed: the lowest free one is the count plus one
								alloc_d     = alloc_q + 1'b1;
								app_id_d    = alloc_q + 1'b1;
								res_id_d    = alloc_q + 1'b1;
								res_st_d    = STAT_OK;
								tgt_ready_d = 1'b1;
								state_d     = S_AP_START;
							end
						end
						FUNC_SCHEDULE: begin
							tgt_ready_d = 1'b1;
							state_d     = S_POP_START;
						end
						FUNC_SLEEP: begin
							tgt_ready_d = 1'b0;
							app_id_d    = cur_ok ? IW'(req.current_task) : '0;
							state_d     = S_AP_START;
						end
						FUNC_WAKEUP: begin
							tgt_ready_d = 1'b0;
							state_d     = S_POP_START;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end

			S_AP_START: begin
				if (!id_ok(app_id_q)) begin
					ap_end = 1'b1;
				end else if (!id_ok(head_cur)) begin
					// empty queue: the new ID becomes the head
					head_we  = 1'b1;
					head_val = app_id_q;
					state_d  = S_AP_CLR;
				end else if (head_cur == app_id_q) begin
					ap_end = 1'b1;
				end else begin
					nl_re    = 1'b1;
					nl_raddr = head_cur;
					walk_d   = head_cur;
					steps_d  = '0;
					state_d  = S_AP_WALK;
				end
			end

			S_AP_WALK: begin
				if (!id_ok(nl_rd_q)) begin
					// tail found: link the new ID behind it
					nl_we    = 1'b1;
					nl_waddr = walk_q;
					nl_wdata = app_id_q;
					state_d  = S_AP_CLR;
				end else if (steps_q == NT_LAST) begin
					// walk bound reached: drop the append
					ap_end = 1'b1;
				end else if (nl_rd_q == app_id_q) begin
					// already queued
					ap_end = 1'b1;
				end else begin
					nl_re    = 1'b1;
					nl_raddr = nl_rd_q;
					walk_d   = nl_rd_q;
					steps_d  = steps_q + 1'b1;
				end
			end

			S_AP_CLR: begin
				nl_we    = 1'b1;
				nl_waddr = app_id_q;
				nl_wdata = '0;
				ap_end   = 1'b1;
			end

			S_POP_START: begin
				if (!id_ok(head_cur)) begin
					head_we  = 1'b1;
					head_val = '0;
					pop_end  = 1'b1;
					pop_top  = '0;
				end else begin
					nl_re    = 1'b1;
					nl_raddr = head_cur;
					walk_d   = head_cur;
					state_d  = S_POP_RD;
				end
			end

			S_POP_RD: begin
				// advance the head and unlink the popped task
				head_we  = 1'b1;
				head_val = id_ok(nl_rd_q) ? nl_rd_q : '0;
				nl_we    = 1'b1;
				nl_waddr = walk_q;
				nl_wdata = '0;
				pop_end  = 1'b1;
				pop_top  = walk_q;
			end

			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d.task_id = 4'(res_id_q);
					rsp_d.status  = res_st_q;
					rsp_valid_d   = 1'b1;
					state_d       = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// end of an append: sleep goes on to schedule, the rest report
		if (ap_end) begin
			if (op_q == FUNC_SLEEP) begin
				tgt_ready_d = 1'b1;
				state_d     = S_POP_START;
			end else begin
				state_d = S_DONE;
			end
		end

		// end of a pop: wakeup moves the task to the ready queue
		if (pop_end) begin
			res_id_d = pop_top;
			res_st_d = (pop_top == '0) ? STAT_EMPTY : STAT_OK;
			if ((op_q == FUNC_WAKEUP) && (pop_top != '0)) begin
				app_id_d    = pop_top;
				tgt_ready_d = 1'b1;
				state_d     = S_AP_START;
			end else begin
				state_d = S_DONE;
			end
		end
	end

	// route head updates to the ready head or the wait-head memory
	always_comb begin
		ready_head_d = ready_head_q;
		wh_we        = 1'b0;
		wh_wdata     = head_val;
		if (head_we) begin
			if (tgt_ready_q) begin
				ready_head_d = head_val;
			end else begin
				wh_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= FUNC_CREATE;
			tgt_ready_q  <= 1'b0;
			alloc_q      <= '0;
			ready_head_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				whv_q[i] <= 1'b0;
			end
		end else begin
			state_q      <= state_d;
			op_q         <= op_d;
			tgt_ready_q  <= tgt_ready_d;
			alloc_q      <= alloc_d;
			ready_head_q <= ready_head_d;
			rsp_valid_q  <= rsp_valid_d;
			rsp_q        <= rsp_d;
			if (wh_we) begin
				whv_q[ch_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ch_q     <= ch_d;
		app_id_q <= app_id_d;
		walk_q   <= walk_d;
		steps_q  <= steps_d;
		res_id_q <= res_id_d;
		res_st_q <= res_st_d;
	end

	// link memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (nl_we) begin
			nl_mem[nl_waddr] <= nl_wdata;
		end
		if (nl_re) begin
			nl_rd_q <= nl_mem[nl_raddr];
		end
	end

	// wait-head memory; an entry never written reads as empty via its valid bit
	always_ff @(posedge clk) begin
		if (wh_we) begin
			wh_mem[ch_q] <= wh_wdata;
		end
		if (wh_re) begin
			wh_rd_q  <= wh_mem[wh_raddr];
			whv_rd_q <= whv_q[wh_raddr];
		end
	end

endmodule

// ===== verif/tarwq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarwq_checker: response predictor and scoreboard for the task queue engine
// Watches both beat channels, keeps its own copy of the link table, slot
// marks and queue heads, and compares each response beat with the oldest
// owed result.
// ----------------------------------------------------------------------------
module tarwq_checker #(
	parameter int NUM_TASKS    = 15,
	parameter int NUM_CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  tarwq_pkg::req_t  req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  tarwq_pkg::rsp_t  rsp,
	output int               fail_count,
	output int               pending
);

	import tarwq_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [3:0] link_of [NUM_TASKS+1];
	logic       slot_taken [NUM_TASKS+1];
	logic [3:0] ready_top;
	logic [3:0] chan_top [NUM_CHANNELS];

	rsp_t owed_rsps [$];
	rsp_t want;
	int   mismatches;

	function automatic logic id_ok(input logic [3:0] id);
		return id >= 1 && id <= NUM_TASKS;
	endfunction

	// Link id behind the tail of the queue starting at head; return the new head.
	function automatic logic [3:0] append_id(input logic [3:0] head, input logic [3:0] id);
		logic [3:0] cur;
		logic [3:0] nxt;
		int         step;
		if (!id_ok(id))
			return head;
		if (!id_ok(head)) begin
			link_of[id] = '0;
			return id;
		end
		cur = head;
		for (step = 0; step < NUM_TASKS; step++) begin
			if (cur == id)
				return head;
			nxt = link_of[cur];
			if (!id_ok(nxt)) begin
				link_of[cur] = id;
				link_of[id]  = '0;
				return head;
			end
			cur = nxt;
		end
		// no tail within the walk bound: drop the append
		return head;
	endfunction

	// Unlink the head entry; return the head that follows it.
	function automatic logic [3:0] pop_head(input logic [3:0] head);
		logic [3:0] nxt;
		if (!id_ok(head))
			return '0;
		nxt = link_of[head];
		link_of[head] = '0;
		return id_ok(nxt) ? nxt : '0;
	endfunction

	function automatic rsp_t predict_call(input req_t call);
		rsp_t       res;
		int         ch;
		int         i;
		logic       found;
		logic [3:0] id;
		ch    = int'(call.channel) % NUM_CHANNELS;
		id    = '0;
		found = 1'b0;
		res.status = STAT_OK;
		case (call.func)
			FUNC_CREATE: begin
				res.status = STAT_FULL;
				for (i = 1; i <= NUM_TASKS; i++) begin
					if (!found && !slot_taken[i]) begin
						found         = 1'b1;
						slot_taken[i] = 1'b1;
						id            = 4'(i);
						ready_top     = append_id(ready_top, id);
						res.status    = STAT_OK;
					end
				end
			end
			FUNC_WAKEUP: begin
				id           = id_ok(chan_top[ch]) ? chan_top[ch] : '0;
				chan_top[ch] = pop_head(chan_top[ch]);
				if (id == '0)
					res.status = STAT_EMPTY;
				else
					ready_top = append_id(ready_top, id);
			end
			default: begin
				if (call.func == FUNC_SLEEP)
					chan_top[ch] = append_id(chan_top[ch], call.current_task);
				id         = id_ok(ready_top) ? ready_top : '0;
				ready_top  = pop_head(ready_top);
				res.status = (id == '0) ? STAT_EMPTY : STAT_OK;
			end
		endcase
		res.task_id = id;
		return res;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUM_TASKS; i++) begin
				link_of[i]    = '0;
				slot_taken[i] = 1'b0;
			end
			for (int c = 0; c < NUM_CHANNELS; c++)
				chan_top[c] = '0;
			ready_top = '0;
			owed_rsps.delete();
			mismatches = 0;
		end else begin
			// response first, so a stray beat never matches the call taken this edge
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: MISMATCH unexpected response task_id=%0d status=%0d",
							$realtime, rsp.task_id, rsp.status);
				end else begin
					want = owed_rsps.pop_front();
					if (rsp.task_id !== want.task_id || rsp.status !== want.status) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: MISMATCH task_id exp=%0d act=%0d, status exp=%0d act=%0d",
								$realtime, want.task_id, rsp.task_id, want.status, rsp.status);
					end
				end
			end
			if (req_valid && !req_stall)
				owed_rsps.push_back(predict_call(req));
		end
		pending    <= owed_rsps.size();
		fail_count <= mismatches;
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the task ready and wait queue engine
// Drives kernel calls (create, schedule, sleep, wakeup) through the request
// channel with random gaps and response stalls; a checker beside the block
// predicts every response and reports mismatches.
// ----------------------------------------------------------------------------
module tb_top;

	import tarwq_pkg::*;

	localparam int NUM_TASKS      = 15;
	localparam int NUM_CHANNELS   = 8;
	localparam int RANDOM_CALLS   = 880;
	localparam int HOLD_CYCLES    = 80;
	// leave room behind the longest response, set by the append tail walk
	localparam int DRAIN_CYCLES   = 2 * NUM_TASKS + 12;
	localparam int WATCHDOG_LIMIT = 1000;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	int    fail_count;
	int    pending;
	int    beats_sent;
	int    quiet_cycles = 0;
	logic  calm;       // no idling on either side while set
	logic  hold_ask;   // ask the receiver for its one long hold-off
	logic  hold_done;

	always #5 clk = ~clk;

	task_ready_and_wait_queues #(
		.NUM_TASKS    (NUM_TASKS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	tarwq_checker #(
		.NUM_TASKS    (NUM_TASKS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic req_t make_call(input logic [1:0] func, input int ch, input int cur);
		req_t beat;
		beat.func         = func;
		beat.channel      = 3'(ch);
		beat.current_task = 4'(cur);
		return beat;
	endfunction

	// Random call; most channel picks land on one hot channel so that its
	// wait queue grows long and appends walk far down the links.
	function automatic req_t random_call(input int hot);
		int         roll;
		logic [1:0] func;
		int         ch;
		int         cur;
		roll = $urandom_range(99);
		if (roll < 10)
			func = FUNC_CREATE;
		else if (roll < 35)
			func = FUNC_SCHEDULE;
		else if (roll < 70)
			func = FUNC_SLEEP;
		else
			func = FUNC_WAKEUP;
		ch  = ($urandom_range(99) < 30) ? $urandom_range(NUM_CHANNELS - 1) : hot;
		// a sleeper of 0 is not queued, but the schedule half still runs
		cur = ($urandom_range(99) < 8) ? 0 : $urandom_range(NUM_TASKS, 1);
		return make_call(func, ch, cur);
	endfunction

	// Offer one request beat, maybe after a short gap, and hold it until taken.
	task automatic issue(input req_t beat);
		if (!calm && $urandom_range(99) < 16) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		do @(posedge clk); while (req_stall);
		beats_sent++;
	endtask

	// Drop valid and wait until every owed response has come back.
	task automatic drain_all;
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Receiver: random stalls, one long hold-off on request, none while calm.
	initial begin
		hold_done = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_done) begin
				// hold off long enough for the engine to back up and stall requests
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				rsp_stall <= 1'b0;
			end else if (!calm && $urandom_range(99) < 16) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run when nothing is taken for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat taken for %0d cycles", quiet_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int hot;
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		req          <= '0;
		calm         <= 1'b0;
		hold_ask     <= 1'b0;
		beats_sent   = 0;
		hot          = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queues right after reset.
		issue(make_call(FUNC_SCHEDULE, 0, 1));
		issue(make_call(FUNC_WAKEUP, 7, 0));
		// invalid sleeper of 0 on an empty ready queue
		issue(make_call(FUNC_SLEEP, 0, 0));
		// fill every slot, then one more to hit the no-free-slot case
		for (int i = 0; i < NUM_TASKS; i++)
			issue(make_call(FUNC_CREATE, 0, 0));
		issue(make_call(FUNC_CREATE, 3, 15));
		// queue the highest ID twice on one channel; the second append is ignored
		issue(make_call(FUNC_SLEEP, 5, 15));
		issue(make_call(FUNC_SLEEP, 5, 15));
		issue(make_call(FUNC_WAKEUP, 5, 0));
		issue(make_call(FUNC_WAKEUP, 5, 0));
		issue(make_call(FUNC_SLEEP, 7, 1));
		issue(make_call(FUNC_WAKEUP, 7, 10));

		// Random calls with one calm stretch, one hold-off and one full drain.
		for (int n = 0; n < RANDOM_CALLS; n++) begin
			if (n % 100 == 0)
				hot = $urandom_range(NUM_CHANNELS - 1);
			if (n == 300)
				calm <= 1'b1;
			if (n == 450)
				calm <= 1'b0;
			if (n == 500)
				hold_ask <= 1'b1;
			if (n == 700)
				drain_all();
			issue(random_call(hot));
		end

		drain_all();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d kernel calls: directed corner cases, then a random mix of",
			beats_sent);
		$display("create, schedule, sleep and wakeup under gaps, stalls and a long hold-off.");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d responses still owed", fail_count, pending);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
